// File: hw/rtl/ntage_pkg.sv
// ntage_pkg: request/response word types, request and outcome codes,
// controller-to-datapath command and datapath status structs for the neighbor table
// no dependencies

package ntage_pkg;

  // request codes
  localparam logic [1:0] REQ_HEARD = 2'd0;
  localparam logic [1:0] REQ_PRUNE = 2'd1;
  localparam logic [1:0] REQ_FIND  = 2'd2;

  // outcome codes
  localparam logic [1:0] OUT_UPDATED  = 2'd0;
  localparam logic [1:0] OUT_INSERTED = 2'd1;
  localparam logic [1:0] OUT_REPLACED = 2'd2;
  localparam logic [1:0] OUT_NONE     = 2'd3;

  // fixed field widths
  localparam int unsigned SLOT_W    = 4;
  localparam int unsigned COUNT_W   = 5;
  localparam logic [31:0] COUNT_MAX = 32'd31;

  // timeout register reset value and register decode
  localparam logic [31:0] TIMEOUT_RST  = 32'd30000;
  localparam int unsigned APB_ADDR_W   = 3;
  localparam logic        REG_TIMEOUT  = 1'b0;

  // input word
  typedef struct packed {
    logic [1:0]  req_type;
    logic [47:0] mac;
    logic [7:0]  node_id;
    logic [31:0] now_ms;
  } ntage_req_t;

  // result word
  typedef struct packed {
    logic         found;
    logic [3:0]   slot;
    logic [7:0]   found_node;
    logic [31:0]  found_time;
    logic [1:0]   outcome;
    logic [4:0]   pruned_count;
    logic [4:0]   active_count;
  } ntage_rsp_t;

  // controller commands
  typedef struct packed {
    logic load;
    logic issue;
    logic commit;
  } ntage_cmd_t;

  // datapath status
  typedef struct packed {
    logic last;
  } ntage_sts_t;

  // saturate a count to the 5-bit result field
  function automatic logic [COUNT_W-1:0] sat_count(input logic [31:0] v);
    logic [COUNT_W-1:0] r;
    if (v > COUNT_MAX) begin
      r = COUNT_MAX[COUNT_W-1:0];
    end else begin
      r = v[COUNT_W-1:0];
    end
    return r;
  endfunction

endpackage

// File: hw/rtl/ntage_ctrl.sv
// ntage_ctrl: sequencer for one request: load, scan of all entries,
// pipeline flush, commit and result strobe
// depends on ntage_pkg

module ntage_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  ntage_pkg::ntage_sts_t sts_i,
  output ntage_pkg::ntage_cmd_t cmd_o,
  output logic                  busy_o,
  output logic                  done_o
);
  import ntage_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FLUSH,
    S_COMMIT
  } state_e;

  state_e state_q;
  logic   busy_q;
  logic   done_q;

  // commands follow the state
  always_comb begin
    cmd_o.load   = (state_q == S_IDLE) && start_i;
    cmd_o.issue  = (state_q == S_SCAN);
    cmd_o.commit = (state_q == S_COMMIT);
  end

  // state and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      busy_q  <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (start_i) begin
            state_q <= S_SCAN;
            busy_q  <= 1'b1;
          end
        end
        S_SCAN: begin
          if (sts_i.last) begin
            state_q <= S_FLUSH;
          end
        end
        S_FLUSH: begin
          state_q <= S_COMMIT;
        end
        S_COMMIT: begin
          state_q <= S_IDLE;
          busy_q  <= 1'b0;
          done_q  <= 1'b1;
        end
        default: begin
          state_q <= S_IDLE;
          busy_q  <= 1'b0;
        end
      endcase
    end
  end

  assign busy_o = busy_q;
  assign done_o = done_q;

`ifndef SYNTHESIS
  a_start_scans: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE && start_i) |=> (state_q == S_SCAN && busy_q))
    else $error("accepted request did not start a scan");

  a_done_after_commit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> ($past(state_q) == S_COMMIT))
    else $error("result strobe without a commit");

  a_flush_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FLUSH) |-> ($past(state_q) == S_SCAN && $past(sts_i.last)))
    else $error("flush entered before the last entry was read");
`endif

endmodule

// File: hw/rtl/ntage_dpath.sv
// ntage_dpath: entry memories, valid bits, active count, scan pipeline
// with match / free / oldest search, prune aging and result register
// depends on ntage_pkg

module ntage_dpath #(
  parameter int unsigned DEPTH = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  ntage_pkg::ntage_cmd_t cmd_i,
  output ntage_pkg::ntage_sts_t sts_o,
  input  ntage_pkg::ntage_req_t req_i,
  input  logic [31:0]           timeout_i,
  output ntage_pkg::ntage_rsp_t rsp_o
);
  import ntage_pkg::*;

  localparam int unsigned IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(DEPTH - 1);

  // entry storage
  logic [47:0] mac_mem  [DEPTH];
  logic [7:0]  node_mem [DEPTH];
  logic [31:0] time_mem [DEPTH];

  // control state
  logic [DEPTH-1:0] valid_q;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [CNT_W-1:0] pruned_q;
  logic [IDX_W-1:0] idx_q;
  logic             rd_vld_q;
  logic             hit_q, free_q;

  // payload registers
  ntage_req_t       req_q;
  logic [IDX_W-1:0] rd_idx_q;
  logic [47:0]      rd_mac_q;
  logic [7:0]       rd_node_q;
  logic [31:0]      rd_time_q;
  logic [IDX_W-1:0] hit_idx_q, free_idx_q, min_idx_q;
  logic [7:0]       hit_node_q;
  logic [31:0]      hit_time_q, min_time_q;
  ntage_rsp_t       rsp_q, rsp_d;

  logic             is_heard, is_prune, is_find;
  logic             ent_valid, mac_eq, aged;
  logic [31:0]      age;
  logic             hit_now, free_now, min_upd, prune_now;
  logic             wr_en, wr_new, ins_free;
  logic [IDX_W-1:0] wr_idx;

  assign sts_o.last = (idx_q == IDX_LAST);

  // request decode
  assign is_heard = (req_q.req_type == REQ_HEARD);
  assign is_prune = (req_q.req_type == REQ_PRUNE);
  assign is_find  = (req_q.req_type == REQ_FIND);

  // compare stage on the registered read word
  always_comb begin
    ent_valid = valid_q[rd_idx_q];
    mac_eq    = (rd_mac_q == req_q.mac);
    age       = req_q.now_ms - rd_time_q;
    aged      = (age > timeout_i);
    hit_now   = rd_vld_q && ent_valid && mac_eq && !hit_q && (is_heard || is_find);
    free_now  = rd_vld_q && !ent_valid && !free_q;
    min_upd   = rd_vld_q && ((rd_idx_q == '0) || (rd_time_q < min_time_q));
    prune_now = rd_vld_q && is_prune && ent_valid && aged;
  end

  // commit: refresh a hit, else fill the first free slot, else the oldest
  always_comb begin
    wr_en    = cmd_i.commit && is_heard;
    wr_new   = wr_en && !hit_q;
    ins_free = wr_new && free_q;
    if (hit_q) begin
      wr_idx = hit_idx_q;
    end else if (free_q) begin
      wr_idx = free_idx_q;
    end else begin
      wr_idx = min_idx_q;
    end
  end

  // active count follows set and clear of valid bits
  always_comb begin
    cnt_d = cnt_q;
    if (prune_now) begin
      cnt_d = cnt_q - CNT_W'(1);
    end else if (ins_free) begin
      cnt_d = cnt_q + CNT_W'(1);
    end
  end

  // result word
  always_comb begin
    rsp_d              = '0;
    rsp_d.outcome      = OUT_NONE;
    rsp_d.pruned_count = sat_count(32'(pruned_q));
    rsp_d.active_count = sat_count(32'(cnt_d));
    if (is_heard) begin
      rsp_d.slot = SLOT_W'(wr_idx);
      if (hit_q) begin
        rsp_d.found      = 1'b1;
        rsp_d.found_node = req_q.node_id;
        rsp_d.found_time = req_q.now_ms;
        rsp_d.outcome    = OUT_UPDATED;
      end else if (free_q) begin
        rsp_d.outcome = OUT_INSERTED;
      end else begin
        rsp_d.outcome = OUT_REPLACED;
      end
    end else if (is_find && hit_q) begin
      rsp_d.found      = 1'b1;
      rsp_d.slot       = SLOT_W'(hit_idx_q);
      rsp_d.found_node = hit_node_q;
      rsp_d.found_time = hit_time_q;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      cnt_q    <= '0;
      pruned_q <= '0;
      idx_q    <= '0;
      rd_vld_q <= 1'b0;
      hit_q    <= 1'b0;
      free_q   <= 1'b0;
    end else begin
      rd_vld_q <= cmd_i.issue;
      cnt_q    <= cnt_d;
      if (cmd_i.load) begin
        idx_q    <= '0;
        pruned_q <= '0;
        hit_q    <= 1'b0;
        free_q   <= 1'b0;
      end else begin
        if (cmd_i.issue) begin
          idx_q <= idx_q + IDX_W'(1);
        end
        if (hit_now) begin
          hit_q <= 1'b1;
        end
        if (free_now) begin
          free_q <= 1'b1;
        end
        if (prune_now) begin
          valid_q[rd_idx_q] <= 1'b0;
          pruned_q          <= pruned_q + CNT_W'(1);
        end
        if (ins_free) begin
          valid_q[free_idx_q] <= 1'b1;
        end
      end
    end
  end

  // request and search payload
  always_ff @(posedge clk_i) begin
    rd_idx_q <= idx_q;
    if (cmd_i.load) begin
      req_q <= req_i;
    end
    if (hit_now) begin
      hit_idx_q  <= rd_idx_q;
      hit_node_q <= rd_node_q;
      hit_time_q <= rd_time_q;
    end
    if (free_now) begin
      free_idx_q <= rd_idx_q;
    end
    if (min_upd) begin
      min_idx_q  <= rd_idx_q;
      min_time_q <= rd_time_q;
    end
    if (cmd_i.commit) begin
      rsp_q <= rsp_d;
    end
  end

  // memory read port, registered
  always_ff @(posedge clk_i) begin
    rd_mac_q  <= mac_mem[idx_q];
    rd_node_q <= node_mem[idx_q];
    rd_time_q <= time_mem[idx_q];
  end

  // memory write port
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      node_mem[wr_idx] <= req_q.node_id;
      time_mem[wr_idx] <= req_q.now_ms;
    end
    if (wr_new) begin
      mac_mem[wr_idx] <= req_q.mac;
    end
  end

  assign rsp_o = rsp_q;

`ifndef SYNTHESIS
  a_count_matches_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'($countones(valid_q)) == 32'(cnt_q))
    else $error("active count out of step with valid bits");

  a_found_only_update: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.commit |=> !(rsp_q.found &&
                       (rsp_q.outcome == OUT_INSERTED || rsp_q.outcome == OUT_REPLACED)))
    else $error("found flagged on an insert or replace");

  a_insert_sets_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ins_free |=> valid_q[$past(free_idx_q)])
    else $error("insert into a free slot left it invalid");
`endif

endmodule

// File: hw/rtl/neighbor_table_aging.sv
// neighbor_table_aging: top level, apb timeout register, controller and datapath
// depends on ntage_pkg, ntage_ctrl, ntage_dpath
//
//  channel  | handshake                  | word
//  ---------+----------------------------+--------------------------------
//  request  | start_i, busy_o            | req_i  (req_type, mac, node_id, now_ms)
//  result   | done_o (one-cycle strobe)  | rsp_o  (found ... active_count)
//  config   | psel/penable/pwrite/pready | paddr, pwdata, prdata (timeout_ms at 0x0)
//
// a request scans every entry through the single read port of the entry memory,
// then flushes the read register and commits
// a new request can be accepted in the cycle that carries the result strobe
// reset clears all valid bits and the count at once, timeout_ms returns to 30000
// the receiver cannot stall; the receiver is to treat the result word as valid only
// while done_o is high; the block itself does not enforce this, rsp_o holds

module neighbor_table_aging #(
  parameter int unsigned TABLE_DEPTH = 16
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   start_i,
  input  ntage_pkg::ntage_req_t                  req_i,
  output logic                                   busy_o,
  output logic                                   done_o,
  output ntage_pkg::ntage_rsp_t                  rsp_o,
  input  logic                                   psel,
  input  logic                                   penable,
  input  logic                                   pwrite,
  input  logic [ntage_pkg::APB_ADDR_W-1:0]       paddr,
  input  logic [31:0]                            pwdata,
  output logic [31:0]                            prdata,
  output logic                                   pready
);
  import ntage_pkg::*;

  logic [31:0] timeout_q;
  logic        reg_wr;
  ntage_cmd_t  cmd;
  ntage_sts_t  sts;

  // apb register access
  assign pready = 1'b1;
  assign reg_wr = psel && penable && pwrite && (paddr[APB_ADDR_W-1] == REG_TIMEOUT);
  assign prdata = (paddr[APB_ADDR_W-1] == REG_TIMEOUT) ? timeout_q : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q <= TIMEOUT_RST;
    end else if (reg_wr) begin
      timeout_q <= pwdata;
    end
  end

  // sequencer
  ntage_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .sts_i   (sts),
    .cmd_o   (cmd),
    .busy_o  (busy_o),
    .done_o  (done_o)
  );

  // table and search logic
  ntage_dpath #(
    .DEPTH (TABLE_DEPTH)
  ) u_dpath (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (cmd),
    .sts_o     (sts),
    .req_i     (req_i),
    .timeout_i (timeout_q),
    .rsp_o     (rsp_o)
  );

endmodule
